// ===== sv/nrcrc_pkg.sv =====
// Shared constants, polynomial tables and cell control type for the NR CRC engine.
package nrcrc_pkg;

    localparam int MAX_CRC_LEN_DEF = 24;
    localparam int POLY_W          = 24;
    localparam int KIND_W          = 3;
    localparam int LEN_W           = 5;
    localparam int SEEN_W          = 5;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 3;

    localparam logic [SEEN_W-1:0] SEEN_MAX = 5'd31;

    localparam logic [KIND_W-1:0] KIND_CRC6   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CRC11  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CRC16  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CRC24A = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CRC24B = 3'd4;
    localparam logic [KIND_W-1:0] KIND_CRC24C = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_CRC_KIND    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_APPEND_MODE = 1'd1;

    typedef struct packed {
        logic step;
        logic clear;
        logic d_shift;
        logic load_a;
        logic conv;
        logic fb_r;
        logic fb_a;
    } cell_ctrl_t;

    // reserved kinds fall back to crc24a
    function automatic logic [LEN_W-1:0] crc_len(input logic [KIND_W-1:0] kind);
        logic [LEN_W-1:0] len;
        unique case (kind)
            KIND_CRC6:  len = 5'd6;
            KIND_CRC11: len = 5'd11;
            KIND_CRC16: len = 5'd16;
            default:    len = 5'd24;
        endcase
        return len;
    endfunction

    function automatic logic [POLY_W-1:0] crc_poly(input logic [KIND_W-1:0] kind);
        logic [POLY_W-1:0] poly;
        unique case (kind)
            KIND_CRC6:   poly = 24'h000021;
            KIND_CRC11:  poly = 24'h000621;
            KIND_CRC16:  poly = 24'h001021;
            KIND_CRC24B: poly = 24'h800063;
            KIND_CRC24C: poly = 24'hB2B117;
            default:     poly = 24'h864CFB;
        endcase
        return poly;
    endfunction

endpackage

// ===== sv/nrcrc_if.sv =====
// Valid/ready stream interfaces for the input bits and the result bits.
interface nrcrc_in_if;
    logic valid;
    logic ready;
    logic data_bit;
    logic frame_end;

    modport source (output valid, data_bit, frame_end, input ready);
    modport sink   (input valid, data_bit, frame_end, output ready);
endinterface

interface nrcrc_out_if;
    logic valid;
    logic ready;
    logic out_bit;
    logic is_parity;
    logic run_end;

    modport source (output valid, out_bit, is_parity, run_end, input ready);
    modport sink   (input valid, out_bit, is_parity, run_end, output ready);
endinterface

// ===== sv/nr_crc_attach_and_check.sv =====
// Top level: 5G NR CRC attach/check engine built as a chain of one-bit cells.
// Results are registered: an input transfer's first result appears in the cycle after it is accepted.
// One input bit per cycle unless stalled; a frame end adds L parity bits (L = CRC length).
// A configuration write blocks input while the augmented remainder is rebuilt.
// Reset (rst_n low, async): remainders, delay line and counters clear; crc24a, append mode.
module nr_crc_attach_and_check
    import nrcrc_pkg::*;
#(
    parameter int MAX_CRC_LEN = MAX_CRC_LEN_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    nrcrc_in_if.sink              msg,
    nrcrc_out_if.source           res
);

    localparam int LW = $clog2(MAX_CRC_LEN + 1);
    localparam int IW = $clog2(MAX_CRC_LEN);

    logic [KIND_W-1:0]      crc_kind_reg;
    logic                   append_mode_reg;
    logic                   conv_load_reg;
    logic [LW-1:0]          conv_cnt_reg, conv_cnt_next;
    logic [SEEN_W-1:0]      bits_seen_reg, bits_seen_next;

    logic [LEN_W-1:0]       len_full;
    logic [LW-1:0]          len_cur;
    logic [IW-1:0]          top_idx;
    logic [POLY_W-1:0]      poly_full;
    logic [MAX_CRC_LEN-1:0] r_q, a_q, d_q, r_st, a_st, en_vec;
    logic [MAX_CRC_LEN-1:0] par_src, par_val;
    logic [LW-1:0]          par_sh;
    cell_ctrl_t             ctrl;
    logic                   accept;
    logic                   out_free;
    logic                   data_valid;
    logic                   data_out;

    assign len_full  = crc_len(crc_kind_reg);
    assign len_cur   = (len_full > LEN_W'(MAX_CRC_LEN)) ? LW'(MAX_CRC_LEN) : LW'(len_full);
    assign top_idx   = IW'(len_cur - LW'(1));
    assign poly_full = crc_poly(crc_kind_reg);

    assign msg.ready = out_free && !conv_load_reg && (conv_cnt_reg == '0);
    assign accept    = msg.valid & msg.ready;

    always_comb
    begin
        ctrl.step    = accept;
        ctrl.clear   = accept & msg.frame_end;
        ctrl.d_shift = !append_mode_reg;
        ctrl.load_a  = conv_load_reg;
        ctrl.conv    = (conv_cnt_reg != '0);
        ctrl.fb_r    = r_q[top_idx];
        ctrl.fb_a    = a_q[top_idx] ^ (accept & msg.data_bit);
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_CRC_LEN; gi++)
        begin : g_cell
            logic r_in, a_in, d_in;
            assign en_vec[gi] = (LW'(gi) < len_cur);
            if (gi == 0)
            begin : g_head
                assign r_in = msg.data_bit;
                assign a_in = 1'b0;
                assign d_in = msg.data_bit;
            end
            else
            begin : g_body
                assign r_in = r_q[gi-1];
                assign a_in = a_q[gi-1];
                assign d_in = d_q[gi-1];
            end
            nrcrc_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .ctrl  (ctrl),
                .en    (en_vec[gi]),
                .poly  (poly_full[gi]),
                .r_in  (r_in),
                .a_in  (a_in),
                .d_in  (d_in),
                .r_q   (r_q[gi]),
                .a_q   (a_q[gi]),
                .d_q   (d_q[gi]),
                .r_st  (r_st[gi]),
                .a_st  (a_st[gi])
            );
        end
    endgenerate

    // append: x^L * M mod g, check: M mod g
    assign par_src = append_mode_reg ? a_st : r_st;
    assign par_sh  = LW'(MAX_CRC_LEN) - len_cur;
    assign par_val = par_src << par_sh;

    assign data_valid = append_mode_reg || (bits_seen_reg >= SEEN_W'(len_cur));
    assign data_out   = append_mode_reg ? msg.data_bit : d_q[top_idx];

    nrcrc_out_stage #(
        .MAX_CRC_LEN (MAX_CRC_LEN)
    ) u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .data_valid (data_valid),
        .data_bit   (data_out),
        .par_load   (msg.frame_end),
        .par_val    (par_val),
        .par_len    (len_cur),
        .free       (out_free),
        .res        (res)
    );

    always_comb
    begin
        bits_seen_next = bits_seen_reg;
        if (accept)
        begin
            if (msg.frame_end)
                bits_seen_next = '0;
            else if (!append_mode_reg && (bits_seen_reg != SEEN_MAX))
                bits_seen_next = bits_seen_reg + SEEN_W'(1);
        end
    end

    always_comb
    begin
        conv_cnt_next = conv_cnt_reg;
        if (conv_load_reg)
            conv_cnt_next = len_cur;
        else if (conv_cnt_reg != '0)
            conv_cnt_next = conv_cnt_reg - LW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_kind_reg    <= KIND_CRC24A;
            append_mode_reg <= 1'b1;
            conv_load_reg   <= 1'b0;
            conv_cnt_reg    <= '0;
            bits_seen_reg   <= '0;
        end
        else
        begin
            conv_load_reg <= cfg_we;
            conv_cnt_reg  <= conv_cnt_next;
            bits_seen_reg <= bits_seen_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_CRC_KIND:    crc_kind_reg    <= cfg_data;
                    CFG_APPEND_MODE: append_mode_reg <= cfg_data[0];
                endcase
            end
        end
    end

endmodule

// ===== sv/nrcrc_cell.sv =====
// One bit slice of the CRC chain: remainder, augmented remainder and delay bits.
module nrcrc_cell
    import nrcrc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic       en,
    input  logic       poly,
    input  logic       r_in,
    input  logic       a_in,
    input  logic       d_in,
    output logic       r_q,
    output logic       a_q,
    output logic       d_q,
    output logic       r_st,
    output logic       a_st
);

    logic r_reg, a_reg, d_reg;
    logic r_next, a_next, d_next;
    logic d_st;

    always_comb
    begin
        r_st = en & (r_in ^ (ctrl.fb_r & poly));
        a_st = en & (a_in ^ (ctrl.fb_a & poly));
        d_st = ctrl.d_shift ? (en & d_in) : (en & d_reg);
    end

    always_comb
    begin
        r_next = r_reg;
        a_next = a_reg;
        d_next = d_reg;
        if (ctrl.clear)
        begin
            r_next = 1'b0;
            a_next = 1'b0;
            d_next = 1'b0;
        end
        else if (ctrl.step)
        begin
            r_next = r_st;
            a_next = a_st;
            d_next = d_st;
        end
        else if (ctrl.load_a)
        begin
            a_next = en & r_reg;
        end
        else if (ctrl.conv)
        begin
            a_next = a_st;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_reg <= 1'b0;
            a_reg <= 1'b0;
            d_reg <= 1'b0;
        end
        else
        begin
            r_reg <= r_next;
            a_reg <= a_next;
            d_reg <= d_next;
        end
    end

    assign r_q = r_reg;
    assign a_q = a_reg;
    assign d_q = d_reg;

endmodule

// ===== sv/nrcrc_out_stage.sv =====
// Result register: one pending data bit followed by a left-aligned parity burst.
module nrcrc_out_stage
    import nrcrc_pkg::*;
#(
    parameter int MAX_CRC_LEN = MAX_CRC_LEN_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 load,
    input  logic                                 data_valid,
    input  logic                                 data_bit,
    input  logic                                 par_load,
    input  logic [MAX_CRC_LEN-1:0]               par_val,
    input  logic [$clog2(MAX_CRC_LEN+1)-1:0]     par_len,
    output logic                                 free,
    nrcrc_out_if.source                          res
);

    localparam int LW = $clog2(MAX_CRC_LEN + 1);

    logic                   dv_reg, dv_next;
    logic                   dbit_reg, dbit_next;
    logic [LW-1:0]          pcnt_reg, pcnt_next;
    logic [MAX_CRC_LEN-1:0] p_reg, p_next;
    logic                   xfer;

    assign res.valid     = dv_reg | (pcnt_reg != '0);
    assign res.out_bit   = dv_reg ? dbit_reg : p_reg[MAX_CRC_LEN-1];
    assign res.is_parity = !dv_reg;
    assign res.run_end   = !dv_reg && (pcnt_reg == LW'(1));
    assign xfer          = res.valid & res.ready;

    always_comb
    begin
        if (dv_reg)
            free = xfer && (pcnt_reg == '0);
        else
            free = (pcnt_reg == '0) || ((pcnt_reg == LW'(1)) && xfer);
    end

    always_comb
    begin
        dv_next   = dv_reg;
        dbit_next = dbit_reg;
        pcnt_next = pcnt_reg;
        p_next    = p_reg;
        if (load)
        begin
            dv_next   = data_valid;
            dbit_next = data_bit;
            pcnt_next = par_load ? par_len : '0;
            p_next    = par_val;
        end
        else if (xfer)
        begin
            if (dv_reg)
                dv_next = 1'b0;
            else
            begin
                pcnt_next = pcnt_reg - LW'(1);
                p_next    = {p_reg[MAX_CRC_LEN-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg   <= 1'b0;
            pcnt_reg <= '0;
        end
        else
        begin
            dv_reg   <= dv_next;
            pcnt_reg <= pcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dbit_reg <= dbit_next;
        p_reg    <= p_next;
    end

endmodule

// ===== sv/nrcrc_checker.sv =====
// Port-level checker for the NR CRC engine, bound to the top level.
module nrcrc_checker
(
    input logic clk,
    input logic rst_n,
    input logic cfg_we,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_bit,
    input logic is_parity,
    input logic run_end
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_bit)
            && $stable(is_parity) && $stable(run_end))
        else $error("result changed while stalled");

    a_end_is_parity: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && run_end |-> is_parity)
        else $error("run_end on a data bit");

    a_burst_cont: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && is_parity && !run_end |=> out_valid && is_parity)
        else $error("parity burst broken");

    a_burst_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_parity && !run_end |-> !in_ready)
        else $error("input taken during parity burst");

    a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !in_ready)
        else $error("input taken right after config write");

endmodule

bind nr_crc_attach_and_check nrcrc_checker u_nrcrc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .in_ready  (msg.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_bit   (res.out_bit),
    .is_parity (res.is_parity),
    .run_end   (res.run_end)
);

// ===== test/nr_crc_attach_and_check_test.sv =====
// Self-checking bench for the NR CRC attach/check engine: directed table, then random frames.
module nr_crc_attach_and_check_test;
    import nrcrc_pkg::*;

    localparam int CRC_MAX     = MAX_CRC_LEN_DEF;
    localparam int RAND_ITEMS  = 140;
    localparam int SETTLE      = 4;
    localparam int DRAIN       = 20;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PLAN_LEN    = 35;

    localparam logic [KIND_W-1:0]     KIND_RSVD6  = 3'd6;
    localparam logic [KIND_W-1:0]     KIND_RSVD7  = 3'd7;
    localparam logic [CFG_DATA_W-1:0] MODE_CHECK  = 3'd0;
    localparam logic [CFG_DATA_W-1:0] MODE_APPEND = 3'd1;
    localparam logic [15:0]           STALL_PAT   = 16'b1101_0110_0111_1010;

    typedef enum logic [1:0] {ROW_CFG, ROW_BIT, ROW_PIN} row_kind_e;
    typedef enum logic [1:0] {RX_OPEN, RX_PATTERN, RX_RANDOM} rx_mode_e;

    typedef struct packed {
        logic out_bit;
        logic is_parity;
        logic run_end;
    } crc_bit_t;

    typedef struct packed {
        row_kind_e              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  val;
        logic                   din;
        logic                   fin;
        logic                   echo;
        logic [LEN_W-1:0]       plen;
        logic [POLY_W-1:0]      pcrc;
    } plan_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    nrcrc_in_if  msg_ch ();
    nrcrc_out_if res_ch ();

    nr_crc_attach_and_check dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .msg       (msg_ch),
        .res       (res_ch)
    );

    // predictor state
    logic [KIND_W-1:0] kind_r;
    logic              append_r;
    logic [POLY_W-1:0] div_reg;
    logic [POLY_W-1:0] rx_hist;
    logic [SEEN_W-1:0] rx_count;

    crc_bit_t  step_out [$];
    crc_bit_t  bits_due [$];
    crc_bit_t  seen_bit;
    crc_bit_t  due_bit;
    plan_row_t plan [PLAN_LEN];

    int       fails;
    int       cycles;
    int       items_sent;
    int       burst_left;
    logic     steady;
    int       hold_req;
    int       hold_seen;
    int       hold_left;
    int       stall_left;
    rx_mode_e stall_mode;
    logic [3:0] pat_pos;

    always #5 clk = ~clk;

    function automatic void add_bit(ref crc_bit_t q[$], input crc_bit_t b);
        q.insert(q.size(), b);
    endfunction

    function automatic void gen_for(input logic [KIND_W-1:0] k, output int len,
                                    output logic [POLY_W-1:0] g, output logic [POLY_W-1:0] m);
        logic [POLY_W:0] one_hot;
        case (k)
            KIND_CRC6:   begin len = 6;  g = 24'h000021; end
            KIND_CRC11:  begin len = 11; g = 24'h000621; end
            KIND_CRC16:  begin len = 16; g = 24'h001021; end
            KIND_CRC24B: begin len = 24; g = 24'h800063; end
            KIND_CRC24C: begin len = 24; g = 24'hB2B117; end
            default:     begin len = 24; g = 24'h864CFB; end
        endcase
        if (len > CRC_MAX)
            len = CRC_MAX;
        one_hot = 25'd1 << len;
        m = POLY_W'(one_hot - 25'd1);
        g &= m;
    endfunction

    function automatic logic [POLY_W-1:0] div_step(input logic [POLY_W-1:0] r, input logic b,
                                                   input int len, input logic [POLY_W-1:0] g,
                                                   input logic [POLY_W-1:0] m);
        logic top;
        top = r[len-1];
        r = ((r << 1) | POLY_W'(b)) & m;
        if (top)
            r ^= g;
        return r;
    endfunction

    function automatic void crc_engine_step(input logic din, input logic fin);
        int                len;
        int                i;
        logic [POLY_W-1:0] g;
        logic [POLY_W-1:0] m;
        gen_for(kind_r, len, g, m);
        div_reg &= m;
        rx_hist &= m;
        step_out.delete();
        if (append_r)
        begin
            add_bit(step_out, crc_bit_t'{din, 1'b0, 1'b0});
            div_reg = div_step(div_reg, din, len, g, m);
            if (fin)
                for (i = 0; i < len; i++)
                    div_reg = div_step(div_reg, 1'b0, len, g, m);
        end
        else
        begin
            if (rx_count >= len)
                add_bit(step_out, crc_bit_t'{rx_hist[len-1], 1'b0, 1'b0});
            rx_hist = ((rx_hist << 1) | POLY_W'(din)) & m;
            div_reg = div_step(div_reg, din, len, g, m);
            if (rx_count < SEEN_MAX)
                rx_count++;
        end
        if (fin)
        begin
            for (i = len; i > 0; i--)
                add_bit(step_out, crc_bit_t'{div_reg[i-1], 1'b1, i == 1});
            div_reg  = '0;
            rx_hist  = '0;
            rx_count = '0;
        end
    endfunction

    function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
        plan_row_t r;
        r = '0;
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.val  = val;
        return r;
    endfunction

    function automatic plan_row_t bit_row(input logic din, input logic fin);
        plan_row_t r;
        r = '0;
        r.kind = ROW_BIT;
        r.din  = din;
        r.fin  = fin;
        return r;
    endfunction

    // single-row frame whose results are typed in: optional echo, then plen parity bits
    function automatic plan_row_t pin_row(input logic din, input logic echo,
                                          input logic [LEN_W-1:0] plen,
                                          input logic [POLY_W-1:0] pcrc);
        plan_row_t r;
        r = '0;
        r.kind = ROW_PIN;
        r.din  = din;
        r.fin  = 1'b1;
        r.echo = echo;
        r.plen = plen;
        r.pcrc = pcrc;
        return r;
    endfunction

    task automatic send_item(input logic din, input logic fin, input logic pin,
                             input logic echo, input logic [LEN_W-1:0] plen,
                             input logic [POLY_W-1:0] pcrc);
        int gap;
        int i;
        if (!steady && burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            repeat (gap)
            begin
                @(negedge clk);
                msg_ch.valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 16);
        end
        @(negedge clk);
        msg_ch.valid     <= 1'b1;
        msg_ch.data_bit  <= din;
        msg_ch.frame_end <= fin;
        do
            @(posedge clk);
        while (msg_ch.ready !== 1'b1);
        if (burst_left > 0)
            burst_left--;
        items_sent++;
        crc_engine_step(din, fin);
        if (pin)
        begin
            if (echo)
                add_bit(bits_due, crc_bit_t'{din, 1'b0, 1'b0});
            for (i = plen; i > 0; i--)
                add_bit(bits_due, crc_bit_t'{pcrc[i-1], 1'b1, i == 1});
        end
        else
        begin
            foreach (step_out[i])
                add_bit(bits_due, step_out[i]);
        end
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        msg_ch.valid <= 1'b0;
        while (bits_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE)
            @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_CRC_KIND)
            kind_r = val;
        else
            append_r = val[0];
    endtask

    // result sink stall pattern, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (stall_left == 0)
        begin
            stall_mode = rx_mode_e'($urandom_range(0, 2));
            stall_left = $urandom_range(8, 60);
        end
        else
            stall_left--;
        pat_pos = pat_pos + 4'd1;
        if (hold_left > 0)
        begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end
        else
        begin
            case (stall_mode)
                RX_OPEN:    res_ch.ready <= 1'b1;
                RX_PATTERN: res_ch.ready <= STALL_PAT[pat_pos];
                default:    res_ch.ready <= ($urandom_range(0, 2) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            seen_bit = {res_ch.out_bit, res_ch.is_parity, res_ch.run_end};
            if (bits_due.size() == 0)
            begin
                $display("%0t: unexpected transfer: expected none, actual out_bit=%b is_parity=%b run_end=%b",
                         $time, seen_bit.out_bit, seen_bit.is_parity, seen_bit.run_end);
                fails++;
            end
            else
            begin
                due_bit = bits_due.pop_front();
                if (due_bit !== seen_bit)
                begin
                    $display("%0t: mismatch: expected out_bit=%b is_parity=%b run_end=%b,",
                             $time, due_bit.out_bit, due_bit.is_parity, due_bit.run_end);
                    $display("    actual out_bit=%b is_parity=%b run_end=%b",
                             seen_bit.out_bit, seen_bit.is_parity, seen_bit.run_end);
                    fails++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin : main
        int                goal;
        int                mlen;
        int                sel;
        int                midpos;
        int                len;
        int                i;
        logic              hold_done;
        logic [POLY_W-1:0] g;
        logic [POLY_W-1:0] m;
        logic [POLY_W-1:0] r;
        logic              frame [$];

        clk              = 1'b0;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        msg_ch.valid     = 1'b0;
        msg_ch.data_bit  = 1'b0;
        msg_ch.frame_end = 1'b0;
        res_ch.ready     = 1'b0;
        kind_r           = KIND_CRC24A;
        append_r         = 1'b1;
        div_reg          = '0;
        rx_hist          = '0;
        rx_count         = '0;
        fails            = 0;
        cycles           = 0;
        items_sent       = 0;
        burst_left       = 0;
        steady           = 1'b0;
        hold_req         = 0;
        hold_seen        = 0;
        hold_left        = 0;
        stall_left       = 0;
        stall_mode       = RX_OPEN;
        pat_pos          = '0;
        hold_done        = 1'b0;

        plan = '{
            pin_row(1'b1, 1'b1, 5'd24, 24'h864CFB),          // crc24a after reset
            cfg_row(CFG_CRC_KIND, KIND_CRC6),
            pin_row(1'b0, 1'b1, 5'd6, 24'h000000),
            pin_row(1'b1, 1'b1, 5'd6, 24'h000021),
            cfg_row(CFG_CRC_KIND, KIND_CRC11),
            bit_row(1'b1, 1'b0), bit_row(1'b0, 1'b0), bit_row(1'b1, 1'b0), bit_row(1'b1, 1'b1),
            cfg_row(CFG_CRC_KIND, KIND_CRC16),
            bit_row(1'b1, 1'b0), bit_row(1'b1, 1'b1),
            cfg_row(CFG_CRC_KIND, KIND_CRC24B),
            pin_row(1'b1, 1'b1, 5'd24, 24'h800063),
            cfg_row(CFG_CRC_KIND, KIND_CRC24C),
            pin_row(1'b1, 1'b1, 5'd24, 24'hB2B117),
            cfg_row(CFG_CRC_KIND, KIND_RSVD6),                 // reserved kinds act as crc24a
            pin_row(1'b1, 1'b1, 5'd24, 24'h864CFB),
            cfg_row(CFG_CRC_KIND, KIND_RSVD7),
            pin_row(1'b1, 1'b1, 5'd24, 24'h864CFB),
            cfg_row(CFG_APPEND_MODE, MODE_CHECK),
            cfg_row(CFG_CRC_KIND, KIND_CRC6),
            // valid crc6 codeword: message 1, parity 100001
            bit_row(1'b1, 1'b0), bit_row(1'b1, 1'b0), bit_row(1'b0, 1'b0),
            bit_row(1'b0, 1'b0), bit_row(1'b0, 1'b0), bit_row(1'b0, 1'b0),
            bit_row(1'b1, 1'b1),
            // short check frame with a kind change mid-frame: bits come back right-aligned
            bit_row(1'b1, 1'b0), bit_row(1'b0, 1'b0),
            cfg_row(CFG_CRC_KIND, KIND_CRC11),
            pin_row(1'b1, 1'b0, 5'd11, 24'h000005),
            cfg_row(CFG_APPEND_MODE, MODE_APPEND),
            cfg_row(CFG_CRC_KIND, KIND_CRC24A)
        };

        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            case (plan[i].kind)
                ROW_CFG: cfg_write(plan[i].idx, plan[i].val);
                ROW_BIT: send_item(plan[i].din, plan[i].fin, 1'b0, 1'b0, '0, '0);
                default: send_item(plan[i].din, 1'b1, 1'b1, plan[i].echo,
                                   plan[i].plen, plan[i].pcrc);
            endcase
        end

        goal = items_sent + RAND_ITEMS;
        while (items_sent < goal)
        begin
            if ($urandom_range(0, 2) == 0)
                cfg_write(CFG_CRC_KIND, CFG_DATA_W'($urandom_range(0, 7)));
            if ($urandom_range(0, 3) == 0)
                cfg_write(CFG_APPEND_MODE, CFG_DATA_W'($urandom_range(0, 1)));
            steady = ($urandom_range(0, 3) == 0);
            mlen = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
            // long hold-off at the sink while a long frame streams in
            if (!hold_done && items_sent > goal - RAND_ITEMS + 30)
            begin
                hold_done = 1'b1;
                hold_req++;
                steady = 1'b1;
                mlen = 60;
            end
            frame.delete();
            repeat (mlen)
                frame.insert(frame.size(), 1'($urandom_range(0, 1)));
            if (!append_r)
            begin
                sel = $urandom_range(0, 3);
                if (sel != 0)
                begin
                    gen_for(kind_r, len, g, m);
                    r = '0;
                    foreach (frame[i])
                        r = div_step(r, frame[i], len, g, m);
                    repeat (len)
                        r = div_step(r, 1'b0, len, g, m);
                    for (i = len - 1; i >= 0; i--)
                        frame.insert(frame.size(), r[i]);
                    if (sel == 1)
                    begin
                        i = $urandom_range(0, frame.size() - 1);
                        frame[i] = ~frame[i];
                    end
                end
            end
            midpos = -1;
            if (frame.size() > 1 && $urandom_range(0, 9) == 0)
                midpos = $urandom_range(1, frame.size() - 1);
            for (i = 0; i < frame.size(); i++)
            begin
                if (i == midpos)
                begin
                    if ($urandom_range(0, 1) == 0)
                        cfg_write(CFG_CRC_KIND, CFG_DATA_W'($urandom_range(0, 7)));
                    else
                        cfg_write(CFG_APPEND_MODE, CFG_DATA_W'($urandom_range(0, 1)));
                end
                send_item(frame[i], i == frame.size() - 1, 1'b0, 1'b0, '0, '0);
            end
        end

        @(negedge clk);
        msg_ch.valid <= 1'b0;
        while (bits_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN)
            @(posedge clk);
        if (fails == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== nr_crc_attach_and_check.f =====
sv/nrcrc_pkg.sv
sv/nrcrc_if.sv
sv/nrcrc_cell.sv
sv/nrcrc_out_stage.sv
sv/nr_crc_attach_and_check.sv
sv/nrcrc_checker.sv
test/nr_crc_attach_and_check_test.sv
